// File: hw/rtl/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and constants of the page allocator: field widths, action and
// status codes, parameter defaults.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int OFF_W       = 27;
  localparam int STATUS_W    = 3;
  localparam int CFG_W       = 16;
  localparam int CNT_OUT_W   = 8;

  localparam int NUM_PAGES_DEF  = 32768;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int COUNT_BITS_DEF = 8;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_ADDREF = 2'd2,
    ACT_INIT   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 3'd0,
    STS_OOM     = 3'd1,
    STS_BADADDR = 3'd2,
    STS_UNDER   = 3'd3,
    STS_NONZERO = 3'd4,
    STS_OVER    = 3'd5
  } status_e;

endpackage

// File: hw/rtl/refcounted_page_allocator_core.sv
// Order: free and add reference read the count RAM, then the result register loads; an allocate
// on an empty stack loads the result directly, other allocates read the stack top, then the count.
// Initialize sweeps every page first. A result waits while the previous beat is not taken.
// One item at a time; next beat taken in the cycle after the result register loads.
// Reset: stack empty, counts read as zero until the first initialize sweep; no clearing
// pass after reset.
// ----------------------------------------------------------------------------
// refcounted_page_allocator_core
// Page allocator with a LIFO free-page stack and per-page reference counts,
// both held in synchronous RAMs; counts are updated by read-modify-write.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_core
  import rpa_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic [OFF_W-1:0]     page_offset_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [OFF_W-1:0]     granted_offset_o,
  output logic                 returned_to_pool_o,
  output logic [CNT_OUT_W-1:0] count_after_o
);

  localparam int PAGE_W  = $clog2(NUM_PAGES);
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam int PB_BITS = $clog2(PAGE_BYTES);
  localparam int PN_W    = OFF_W - PB_BITS;
  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_TOP,
    ST_EXEC,
    ST_INIT
  } state_e;

  state_e                 state_q, state_d;
  action_e                act_q, act_d;
  logic [PAGE_W-1:0]      idx_q, idx_d;
  logic                   addr_ok_q, addr_ok_d;
  logic [DEPTH_W-1:0]     depth_q, depth_d;
  logic [PAGE_W-1:0]      cursor_q, cursor_d;
  logic                   inited_q, inited_d;
  logic [CFG_W-1:0]       first_q, first_d;
  logic                   out_valid_q, out_valid_d;
  status_e                status_q, status_d;
  logic [OFF_W-1:0]       granted_q, granted_d;
  logic                   returned_q, returned_d;
  logic [CNT_OUT_W-1:0]   cnt_out_q, cnt_out_d;

  logic                   cnt_we, cnt_re;
  logic [PAGE_W-1:0]      cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0]  cnt_wdata, cnt_rdata, cnt_cur, cnt_new;
  logic                   stk_we, stk_re;
  logic [PAGE_W-1:0]      stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic [PN_W-1:0]        page_num;
  logic                   aligned, in_range;

  assign page_num = page_offset_i[OFF_W-1:PB_BITS];
  assign aligned  = (page_offset_i[PB_BITS-1:0] == '0);
  assign in_range = (32'(page_num) >= 32'(first_q)) && (32'(page_num) < 32'(NUM_PAGES));
  assign cnt_cur  = inited_q ? cnt_rdata : '0;

  rpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_PAGES)) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .re_i   (cnt_re),
    .raddr_i(cnt_raddr),
    .rdata_o(cnt_rdata)
  );

  rpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    idx_d       = idx_q;
    addr_ok_d   = addr_ok_q;
    depth_d     = depth_q;
    cursor_d    = cursor_q;
    inited_d    = inited_q;
    first_d     = cfg_we_i ? cfg_wdata_i : first_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    granted_d   = granted_q;
    returned_d  = returned_q;
    cnt_out_d   = cnt_out_q;
    cnt_we      = 1'b0;
    cnt_re      = 1'b0;
    cnt_waddr   = idx_q;
    cnt_raddr   = PAGE_W'(page_num);
    cnt_wdata   = '0;
    cnt_new     = '0;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    stk_waddr   = PAGE_W'(depth_q);
    stk_raddr   = PAGE_W'(depth_q - 1'b1);
    stk_wdata   = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d     = action_e'(action_i);
          idx_d     = PAGE_W'(page_num);
          addr_ok_d = (action_e'(action_i) == ACT_FREE) ? (aligned && in_range) : in_range;
          unique case (action_e'(action_i))
            ACT_ALLOC: begin
              if (depth_q == '0) begin
                state_d = ST_EXEC;
              end else begin
                stk_re  = 1'b1;
                state_d = ST_RD_TOP;
              end
            end
            ACT_FREE, ACT_ADDREF: begin
              cnt_re  = 1'b1;
              state_d = ST_EXEC;
            end
            ACT_INIT: begin
              cursor_d = '0;
              inited_d = 1'b1;
              depth_d  = (32'(first_q) < 32'(NUM_PAGES)) ?
                         DEPTH_W'(32'(NUM_PAGES) - 32'(first_q)) : '0;
              state_d  = ST_INIT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_RD_TOP: begin
        idx_d     = stk_rdata;
        cnt_re    = 1'b1;
        cnt_raddr = stk_rdata;
        state_d   = ST_EXEC;
      end

      ST_INIT: begin
        cnt_we    = 1'b1;
        cnt_waddr = cursor_q;
        cnt_wdata = '0;
        if (32'(cursor_q) >= 32'(first_q)) begin
          stk_we    = 1'b1;
          stk_waddr = PAGE_W'(32'(cursor_q) - 32'(first_q));
          stk_wdata = cursor_q;
        end
        if (cursor_q == LAST_PAGE) begin
          state_d = ST_EXEC;
        end else begin
          cursor_d = cursor_q + 1'b1;
        end
      end

      ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          status_d    = STS_OK;
          granted_d   = '0;
          returned_d  = 1'b0;
          cnt_out_d   = '0;
          unique case (act_q)
            ACT_ALLOC: begin
              if (depth_q == '0) begin
                status_d = STS_OOM;
              end else if (cnt_cur != '0) begin
                status_d  = STS_NONZERO;
                cnt_out_d = CNT_OUT_W'(cnt_cur);
              end else begin
                depth_d   = depth_q - 1'b1;
                cnt_we    = 1'b1;
                cnt_wdata = COUNT_BITS'(1);
                granted_d = OFF_W'({idx_q, PB_BITS'(0)});
                cnt_out_d = CNT_OUT_W'(1);
              end
            end
            ACT_FREE: begin
              cnt_new = cnt_cur - 1'b1;
              if (!addr_ok_q) begin
                status_d = STS_BADADDR;
              end else if (cnt_cur == '0) begin
                status_d = STS_UNDER;
              end else begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_new;
                cnt_out_d = CNT_OUT_W'(cnt_new);
                if (cnt_new == '0) begin
                  returned_d = 1'b1;
                  if (32'(depth_q) < 32'(NUM_PAGES)) begin
                    stk_we  = 1'b1;
                    depth_d = depth_q + 1'b1;
                  end
                end
              end
            end
            ACT_ADDREF: begin
              cnt_new = cnt_cur + 1'b1;
              if (!addr_ok_q) begin
                status_d = STS_BADADDR;
              end else if (cnt_cur == '0) begin
                status_d = STS_UNDER;
              end else if (cnt_cur == '1) begin
                status_d  = STS_OVER;
                cnt_out_d = CNT_OUT_W'(cnt_cur);
              end else begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_new;
                cnt_out_d = CNT_OUT_W'(cnt_new);
              end
            end
            default: status_d = STS_OK;
          endcase
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= '0;
      cursor_q    <= '0;
      inited_q    <= 1'b0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      cursor_q    <= cursor_d;
      inited_q    <= inited_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    idx_q      <= idx_d;
    addr_ok_q  <= addr_ok_d;
    status_q   <= status_d;
    granted_q  <= granted_d;
    returned_q <= returned_d;
    cnt_out_q  <= cnt_out_d;
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign granted_offset_o   = granted_q;
  assign returned_to_pool_o = returned_q;
  assign count_after_o      = cnt_out_q;

endmodule

// File: hw/rtl/rpa_ram.sv
// ----------------------------------------------------------------------------
// rpa_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered when the read enable is high and held otherwise.
// ----------------------------------------------------------------------------
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: hw/rtl/rpa_checker.sv
// ----------------------------------------------------------------------------
// rpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rpa_checker
  import rpa_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [STATUS_W-1:0]  status_o,
  input logic [OFF_W-1:0]     granted_offset_o,
  input logic                 returned_to_pool_o,
  input logic [CNT_OUT_W-1:0] count_after_o
);

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(granted_offset_o) && $stable(count_after_o))
    else $error("result beat changed before it was taken");

  // one item in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STS_OK) |-> (granted_offset_o == '0) && !returned_to_pool_o)
    else $error("failed operation granted or returned a page");

  a_return_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && returned_to_pool_o |-> (status_o == STS_OK) && (count_after_o == '0))
    else $error("page returned with nonzero count");

  a_oom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STS_OOM) |-> (count_after_o == '0))
    else $error("out of memory with nonzero count");

endmodule

bind refcounted_page_allocator_core rpa_checker u_rpa_checker (.*);
